### sv/cham_pkg.sv
`timescale 1ns / 1ps

package cham_pkg;

    localparam int WORD_W     = 16;
    localparam int NUM_WORDS  = 4;
    localparam int ROUNDS     = 80;
    localparam int RK_NUM     = 16;
    localparam int KEY_WORDS  = 8;
    localparam int REG_WORDS  = 4;
    localparam int RND_PER_ST = 2;
    localparam int STAGES     = ROUNDS / RND_PER_ST;
    localparam int ROUND_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    typedef logic [WORD_W-1:0]     t_word;
    typedef t_word [NUM_WORDS-1:0] t_block;
    typedef t_word [RK_NUM-1:0]    t_rk_set;
    typedef logic [ROUND_W-1:0]    t_round;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_KEY_LO = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_KEY_HI = t_cfg_idx'(1);

    typedef struct packed {
        t_word plain_word0;
        t_word plain_word1;
        t_word plain_word2;
        t_word plain_word3;
    } t_plain;

    typedef struct packed {
        t_word cipher_word0;
        t_word cipher_word1;
        t_word cipher_word2;
        t_word cipher_word3;
    } t_cipher;

    function automatic t_word rol(input t_word v, input int unsigned n);
        return t_word'((v << n) | (v >> (WORD_W - n)));
    endfunction

    function automatic t_word round_even(input t_word x0, input t_word x1,
                                         input t_word rk, input t_round r);
        t_word a;
        t_word s;
        a = x0 ^ {{(WORD_W-ROUND_W){1'b0}}, r};
        s = t_word'(a + (rol(x1, 1) ^ rk));
        return rol(s, 8);
    endfunction

    function automatic t_word round_odd(input t_word x0, input t_word x1,
                                        input t_word rk, input t_round r);
        t_word a;
        t_word s;
        a = x0 ^ {{(WORD_W-ROUND_W){1'b0}}, r};
        s = t_word'(a + (rol(x1, 8) ^ rk));
        return rol(s, 1);
    endfunction

endpackage

### sv/cham_key_sched.sv
`timescale 1ns / 1ps

module cham_key_sched (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  cham_pkg::t_cfg_idx i_cfg_index,
    input  cham_pkg::t_cfg_data i_cfg_data,
    output cham_pkg::t_rk_set  o_rk
);

    cham_pkg::t_cfg_data r_key_lo;
    cham_pkg::t_cfg_data r_key_hi;
    cham_pkg::t_cfg_data n_key_lo;
    cham_pkg::t_cfg_data n_key_hi;
    cham_pkg::t_word     key_word [cham_pkg::KEY_WORDS];

    always_comb begin
        n_key_lo = r_key_lo;
        n_key_hi = r_key_hi;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                cham_pkg::CFG_KEY_LO: n_key_lo = i_cfg_data;
                cham_pkg::CFG_KEY_HI: n_key_hi = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
        end else begin
            r_key_lo <= n_key_lo;
            r_key_hi <= n_key_hi;
        end
    end

    // Word 0 of each register sits in its top bits.
    always_comb begin
        for (int i = 0; i < cham_pkg::REG_WORDS; i++) begin
            key_word[i] = r_key_lo[cham_pkg::CFG_DATA_W-1-cham_pkg::WORD_W*i -: cham_pkg::WORD_W];
            key_word[i+cham_pkg::REG_WORDS] =
                r_key_hi[cham_pkg::CFG_DATA_W-1-cham_pkg::WORD_W*i -: cham_pkg::WORD_W];
        end
    end

    // The user must change the key only while no block is in flight;
    // this is unchecked. The schedule is plain XOR logic, unregistered.
    always_comb begin
        for (int i = 0; i < cham_pkg::KEY_WORDS; i++) begin
            o_rk[i] = key_word[i] ^ cham_pkg::rol(key_word[i], 1)
                      ^ cham_pkg::rol(key_word[i], 8);
            o_rk[(i + cham_pkg::KEY_WORDS) ^ 1] = key_word[i]
                      ^ cham_pkg::rol(key_word[i], 1) ^ cham_pkg::rol(key_word[i], 11);
        end
    end

endmodule

### sv/cham_rnd_stage.sv
`timescale 1ns / 1ps

module cham_rnd_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  cham_pkg::t_block i_x,
    input  cham_pkg::t_round i_round,
    input  cham_pkg::t_word  i_rk_even,
    input  cham_pkg::t_word  i_rk_odd,
    output logic             o_valid,
    output cham_pkg::t_block o_x
);

    logic             r_vld;
    cham_pkg::t_block r_x;
    cham_pkg::t_block n_x;
    cham_pkg::t_word  w_even;
    cham_pkg::t_word  w_odd;

    // Two rounds per stage: the even round feeds the odd one through
    // the word window shift.
    always_comb begin
        w_even = cham_pkg::round_even(i_x[0], i_x[1], i_rk_even, i_round);
        w_odd  = cham_pkg::round_odd(i_x[1], i_x[2], i_rk_odd,
                                     i_round | cham_pkg::t_round'(1));
        n_x[0] = i_x[2];
        n_x[1] = i_x[3];
        n_x[2] = w_even;
        n_x[3] = w_odd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
        end
    end

    assign o_valid = r_vld;
    assign o_x     = r_x;

endmodule

### sv/cham_64_128_encrypt.sv
`timescale 1ns / 1ps

// Block cipher encryption, 64-bit block, 128-bit key, 80 rounds. The round
// datapath is unrolled into 40 register stages of two rounds each, behind an
// input register, so a new block is taken every clock while o_ready is high,
// and moves through the stages in order. A one-entry skid register at the
// output holds a result the consumer did not take; while it is full the
// whole pipeline and o_ready hold, and o_ready is driven straight from a
// flop. The round keys are derived combinationally from the two key
// registers, so a key write applies to every block transferred after it;
// write the key only when no block is in flight.
module cham_64_128_encrypt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  cham_pkg::t_cfg_idx  i_cfg_index,
    input  cham_pkg::t_cfg_data i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  cham_pkg::t_plain    i_plain,
    output logic                o_valid,
    input  logic                i_ready,
    output cham_pkg::t_cipher   o_cipher
);

    localparam int LAST = cham_pkg::STAGES;

    cham_pkg::t_rk_set rk;
    logic              en;
    logic [LAST:0]     vld;
    cham_pkg::t_block  x [LAST+1];

    logic              r_in_vld;
    cham_pkg::t_block  r_in_x;
    logic              r_skid_vld;
    logic              n_skid_vld;
    cham_pkg::t_block  r_skid_x;
    cham_pkg::t_block  out_x;

    assign o_cfg_ready = 1'b1;

    cham_key_sched u_key_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rk        (rk)
    );

    assign en      = !r_skid_vld;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_x[0] <= i_plain.plain_word0;
            r_in_x[1] <= i_plain.plain_word1;
            r_in_x[2] <= i_plain.plain_word2;
            r_in_x[3] <= i_plain.plain_word3;
        end
    end

    assign vld[0] = r_in_vld;
    assign x[0]   = r_in_x;

    for (genvar j = 0; j < cham_pkg::STAGES; j++) begin : g_stage
        cham_rnd_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (vld[j]),
            .i_x       (x[j]),
            .i_round   (cham_pkg::t_round'(cham_pkg::RND_PER_ST * j)),
            .i_rk_even (rk[(cham_pkg::RND_PER_ST * j) % cham_pkg::RK_NUM]),
            .i_rk_odd  (rk[(cham_pkg::RND_PER_ST * j + 1) % cham_pkg::RK_NUM]),
            .o_valid   (vld[j+1]),
            .o_x       (x[j+1])
        );
    end

    // The skid register catches the last stage when the pipeline moves on
    // while the consumer is stalled; it always holds the older block.
    always_comb begin
        if (r_skid_vld) begin
            n_skid_vld = !i_ready;
        end else begin
            n_skid_vld = vld[LAST] && !i_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else begin
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld && vld[LAST] && !i_ready) begin
            r_skid_x <= x[LAST];
        end
    end

    assign out_x   = r_skid_vld ? r_skid_x : x[LAST];
    assign o_valid = r_skid_vld || vld[LAST];

    always_comb begin
        o_cipher.cipher_word0 = out_x[0];
        o_cipher.cipher_word1 = out_x[1];
        o_cipher.cipher_word2 = out_x[2];
        o_cipher.cipher_word3 = out_x[3];
    end

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(vld[LAST] && !i_ready))
        else $error("skid register filled without a stalled result");

    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_ready) |=> (r_skid_vld && $stable(r_skid_x)))
        else $error("stalled skid entry changed");

    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_in_vld)
        else $error("transferred block missing from input stage");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |=> $stable(vld[LAST]))
        else $error("last stage moved while skid register was full");

endmodule

### bench/cham_checker.sv
`timescale 1ns / 1ps

// Watches the key, plaintext and ciphertext channels of the encryption core.
// Every plaintext transfer is encrypted here with the key that is loaded at
// that moment, and the ciphertext transfers are compared in order.
module cham_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  cham_pkg::t_cfg_idx  i_cfg_index,
    input  cham_pkg::t_cfg_data i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  cham_pkg::t_plain    i_plain,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cham_pkg::t_cipher   i_cipher,
    output int                  o_mismatches,
    output int                  o_outstanding
);

    import cham_pkg::*;

    t_cfg_data key_lo;
    t_cfg_data key_hi;
    t_cipher   cipher_q[$];
    t_cipher   want;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        key_lo        = '0;
        key_hi        = '0;
    end

    function automatic t_word rotl16(input t_word v, input int unsigned n);
        logic [2*WORD_W-1:0] twice;
        twice = {v, v} << n;
        return twice[2*WORD_W-1 -: WORD_W];
    endfunction

    function automatic t_cipher encrypt_block(input t_plain pt, input t_cfg_data klo,
                                              input t_cfg_data khi);
        t_word   kw[KEY_WORDS];
        t_word   rk[RK_NUM];
        t_word   x[NUM_WORDS];
        t_word   base;
        t_word   sum;
        t_word   fresh;
        t_cipher ct;
        for (int i = 0; i < REG_WORDS; i++) begin
            kw[i]             = klo[CFG_DATA_W-1-WORD_W*i -: WORD_W];
            kw[i + REG_WORDS] = khi[CFG_DATA_W-1-WORD_W*i -: WORD_W];
        end
        for (int i = 0; i < KEY_WORDS; i++) begin
            base               = kw[i] ^ rotl16(kw[i], 1);
            rk[i]              = base ^ rotl16(kw[i], 8);
            rk[(i + 8) ^ 1]    = base ^ rotl16(kw[i], 11);
        end
        x[0] = pt.plain_word0;
        x[1] = pt.plain_word1;
        x[2] = pt.plain_word2;
        x[3] = pt.plain_word3;
        for (int r = 0; r < ROUNDS; r++) begin
            // Even rounds rotate the second word by one and the sum by eight;
            // odd rounds use the two rotations the other way around.
            if (r % 2 == 0) begin
                sum   = t_word'((x[0] ^ t_word'(r)) + (rotl16(x[1], 1) ^ rk[r % RK_NUM]));
                fresh = rotl16(sum, 8);
            end else begin
                sum   = t_word'((x[0] ^ t_word'(r)) + (rotl16(x[1], 8) ^ rk[r % RK_NUM]));
                fresh = rotl16(sum, 1);
            end
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = fresh;
        end
        ct.cipher_word0 = x[0];
        ct.cipher_word1 = x[1];
        ct.cipher_word2 = x[2];
        ct.cipher_word3 = x[3];
        return ct;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_lo = '0;
            key_hi = '0;
            cipher_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_LO: key_lo = i_cfg_data;
                    CFG_KEY_HI: key_hi = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                cipher_q.push_back(encrypt_block(i_plain, key_lo, key_hi));
            end
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: ciphertext %h arrived, expected nothing", $time, i_cipher);
                end else begin
                    want = cipher_q.pop_front();
                    for (int w = 0; w < NUM_WORDS; w++) begin
                        if (want[WORD_W*(NUM_WORDS-w)-1 -: WORD_W]
                                !== i_cipher[WORD_W*(NUM_WORDS-w)-1 -: WORD_W]) begin
                            o_mismatches++;
                            $display("%0t: cipher_word%0d expected %h, got %h", $time, w,
                                     want[WORD_W*(NUM_WORDS-w)-1 -: WORD_W],
                                     i_cipher[WORD_W*(NUM_WORDS-w)-1 -: WORD_W]);
                        end
                    end
                end
            end
        end
        o_outstanding = cipher_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    import cham_pkg::*;

    localparam int       CYCLE_LIMIT   = 1_000_000;
    localparam int       BLOCKS_PER_PH = 250;
    localparam int       NUM_PHASES    = 6;
    localparam int       HOLD_CYCLES   = 400;
    localparam t_cfg_idx CFG_SPARE_2   = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPARE_3   = t_cfg_idx'(3);

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_valid;
    logic      o_cfg_ready;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;
    logic      i_valid;
    logic      o_ready;
    t_plain    i_plain;
    logic      o_valid;
    logic      i_ready;
    t_cipher   o_cipher;

    int   mismatches;
    int   in_flight;
    int   cycle_cnt;
    logic tx_idle_on;
    logic rx_idle_on;
    logic hold_request;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    cham_64_128_encrypt uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_plain     (i_plain),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_cipher    (o_cipher)
    );

    cham_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_plain       (i_plain),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_cipher      (o_cipher),
        .o_mismatches  (mismatches),
        .o_outstanding (in_flight)
    );

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return t_word'($urandom);
        endcase
    endfunction

    function automatic t_plain rand_block();
        return {rand_word(), rand_word(), rand_word(), rand_word()};
    endfunction

    function automatic t_cfg_data rand_key();
        return {$urandom, $urandom};
    endfunction

    // Key writes are only issued while no block is in flight.
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Leaves valid high after the transfer so the next block can follow
    // back to back; a gap lowers it at the following falling edge.
    task automatic send_block(input t_plain blk);
        int gap;
        gap = 0;
        if (tx_idle_on) begin
            case ($urandom_range(0, 19))
                0, 1:    gap = $urandom_range(8, 40);
                2, 3, 4, 5, 6, 7, 8:
                         gap = $urandom_range(1, 3);
                default: gap = 0;
            endcase
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_plain = blk;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (in_flight != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls, and one long hold-off on request.
    initial begin
        int   stall_left;
        int   hold_left;
        logic hold_done;
        i_ready    = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
                i_ready    = 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 2);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_KEY_LO;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_plain      = '0;
        tx_idle_on   = 1'b0;
        rx_idle_on   = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // The all-zero key left by reset.
        send_block('0);
        send_block('1);
        send_block({4{16'h8000}});
        send_block({4{16'h0001}});
        send_block({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
        send_block({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
        drain();

        write_reg(CFG_KEY_LO, '1);
        send_block('0);
        send_block('1);
        drain();
        write_reg(CFG_KEY_HI, '1);
        send_block('0);
        send_block(rand_block());
        drain();

        // Writes to unused indexes must leave the all-ones key in place.
        write_reg(CFG_SPARE_2, '0);
        write_reg(CFG_SPARE_3, rand_key());
        send_block('0);
        send_block(rand_block());
        drain();

        // Published test vector.
        write_reg(CFG_KEY_LO, 64'h0100_0302_0504_0706);
        write_reg(CFG_KEY_HI, 64'h0908_0B0A_0D0C_0F0E);
        send_block({16'h1100, 16'h3322, 16'h5544, 16'h7766});
        send_block('0);
        drain();

        write_reg(CFG_KEY_LO, {4{16'h8000}});
        write_reg(CFG_KEY_HI, {4{16'h0001}});
        send_block('1);
        send_block(rand_block());
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_KEY_LO, '0);
                    write_reg(CFG_KEY_HI, '1);
                end
                2: begin
                    write_reg(CFG_KEY_LO, '1);
                    write_reg(CFG_KEY_HI, '0);
                end
                4: begin
                    write_reg(CFG_KEY_LO, rand_key());
                    write_reg(CFG_SPARE_3, rand_key());
                    write_reg(CFG_KEY_HI, rand_key());
                end
                default: begin
                    write_reg(CFG_KEY_LO, rand_key());
                    write_reg(CFG_KEY_HI, rand_key());
                end
            endcase
            // The first random phase runs at full rate on both sides.
            tx_idle_on = (ph != 0);
            rx_idle_on = (ph != 0);
            for (int n = 0; n < BLOCKS_PER_PH; n++) begin
                if (ph == 2 && n == 20) begin
                    hold_request = 1'b1;
                end
                if (ph == 3 && n == BLOCKS_PER_PH / 2) begin
                    drain();
                end
                send_block(rand_block());
            end
            drain();
        end

        repeat (60) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
